[rtl/core/rsyuv_pkg.sv]
package rsyuv_pkg;

    // Width of one size register on the configuration port.
    localparam int CFG_W = 13;
    localparam int CFG_INDEX_W = 2;
    // Largest size that a register can hold.
    localparam int CFG_MAX = 8191;

    typedef logic [CFG_W-1:0] dim_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_SOURCE_WIDTH  = 2'd0;
    localparam cfg_index_t REG_SOURCE_HEIGHT = 2'd1;
    localparam cfg_index_t REG_TARGET_WIDTH  = 2'd2;
    localparam cfg_index_t REG_TARGET_HEIGHT = 2'd3;

    localparam dim_t RESET_SOURCE_WIDTH  = 13'd1920;
    localparam dim_t RESET_SOURCE_HEIGHT = 13'd1080;
    localparam dim_t RESET_TARGET_WIDTH  = 13'd1280;
    localparam dim_t RESET_TARGET_HEIGHT = 13'd720;

    // BT.601 studio-range coefficients in 8-bit fixed point.
    localparam logic [15:0] Y_R  = 16'd66;
    localparam logic [15:0] Y_G  = 16'd129;
    localparam logic [15:0] Y_B  = 16'd25;
    localparam logic [15:0] CB_R = 16'd38;
    localparam logic [15:0] CB_G = 16'd74;
    localparam logic [15:0] CB_B = 16'd112;
    localparam logic [15:0] CR_R = 16'd112;
    localparam logic [15:0] CR_G = 16'd94;
    localparam logic [15:0] CR_B = 16'd18;
    localparam logic [15:0] ROUND_HALF = 16'd128;
    // Rounding term plus the chroma offset of 128 placed above the shift.
    localparam logic [15:0] CHROMA_BIAS = 16'd32896;
    localparam logic [7:0] LUMA_OFFSET = 8'd16;
    localparam logic [7:0] CHROMA_NEUTRAL = 8'd128;

    // A selected pixel on its way from the position logic to the color stage.
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        chroma_valid;
        logic [11:0] dest_column;
        logic [11:0] dest_row;
        logic        last_of_frame;
    } pix_t;

endpackage

[rtl/core/rgb_scale_to_yuv420.sv]
// Nearest-neighbor down-scaler with BT.601 RGB to YUV 4:2:0 conversion.
//
// Source pixels enter on the s_ channel in raster order, one word per pixel;
// s_tuser marks the first pixel of a frame and clears all positions. Every
// source pixel that the scaler selects leaves as one word on the m_ channel
// with studio-range luma, its destination column and row, and Cb/Cr on even
// rows and columns (m_tuser high). m_tlast marks the last destination pixel
// of the frame. Pixels that are dropped produce no output word.
//
// The four size registers are written through the cfg_ channel, by the user only while no
// frame is in flight; the block does not enforce this. cfg_ready is always high.
//
// One pixel is accepted per cycle while s_tready is high. A selected pixel is held in the
// stage register and its result is then loaded into the output register: the position and
// selection logic works ahead of the stage register, the color multipliers sit between the
// stage and the output register. When the receiver stalls, the two stages fill up and
// s_tready drops only once both are occupied.
// Reset clears positions and restores the default 1920x1080 to 1280x720 sizes.
module rgb_scale_to_yuv420
    import rsyuv_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,    // red, green, blue
    input  logic [0:0]       s_tuser,    // frame_start
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,    // luma, chroma_blue, chroma_red, dest_column, dest_row
    output logic [0:0]       m_tuser,    // chroma_valid
    output logic             m_tlast,    // last_of_frame
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  cfg_index_t       cfg_index,
    input  dim_t             cfg_data
);

    localparam int DIM_MAX = (MAX_DIMENSION > CFG_MAX) ? CFG_MAX : MAX_DIMENSION;
    localparam int POS_W = $clog2(DIM_MAX + 1);
    localparam int PROD_W = 2 * POS_W;
    localparam int SUM_W = PROD_W + 1;
    localparam dim_t DIM_MAX_CFG = CFG_W'(DIM_MAX);

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [PROD_W-1:0] prod_t;

    dim_t source_width_reg, source_height_reg, target_width_reg, target_height_reg;

    pos_t  src_col_reg, src_row_reg, dst_col_reg, dst_row_reg;
    pos_t  src_col_next, src_row_next, dst_col_next, dst_row_next;
    prod_t col_product_reg, col_base_reg, row_product_reg, row_base_reg;
    prod_t col_product_next, col_base_next, row_product_next, row_base_next;

    pix_t  s1_reg, s1_next;
    logic  s1_valid_reg, s1_valid_next;
    logic  out_valid_reg;
    logic [47:0] out_data_reg, out_data_next;
    logic  out_cv_reg, out_last_reg;

    logic  in_accept, s1_advance;
    pos_t  w, h, dw, dh;
    pos_t  c_src_col, c_src_row, c_dst_col, c_dst_row;
    prod_t c_col_product, c_col_base, c_row_product, c_row_base;
    logic  col_sel, row_sel, sel, end_row, end_frame;

    logic [15:0] y_sum, cb_pos, cb_neg, cr_pos, cr_neg, cb_diff, cr_diff;
    logic [7:0]  luma, chroma_blue, chroma_red;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= RESET_SOURCE_WIDTH;
            source_height_reg <= RESET_SOURCE_HEIGHT;
            target_width_reg  <= RESET_TARGET_WIDTH;
            target_height_reg <= RESET_TARGET_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  source_width_reg  <= cfg_data;
                REG_SOURCE_HEIGHT: source_height_reg <= cfg_data;
                REG_TARGET_WIDTH:  target_width_reg  <= cfg_data;
                REG_TARGET_HEIGHT: target_height_reg <= cfg_data;
                default:           source_width_reg  <= source_width_reg;
            endcase
        end
    end

    // Effective sizes: source clamped to [1, max], target clamped to [1, source].
    always_comb
    begin
        if (source_width_reg == '0)
            w = pos_t'(1);
        else if (source_width_reg > DIM_MAX_CFG)
            w = pos_t'(DIM_MAX);
        else
            w = source_width_reg[POS_W-1:0];

        if (source_height_reg == '0)
            h = pos_t'(1);
        else if (source_height_reg > DIM_MAX_CFG)
            h = pos_t'(DIM_MAX);
        else
            h = source_height_reg[POS_W-1:0];

        if (target_width_reg == '0)
            dw = pos_t'(1);
        else if (target_width_reg > CFG_W'(w))
            dw = w;
        else
            dw = target_width_reg[POS_W-1:0];

        if (target_height_reg == '0)
            dh = pos_t'(1);
        else if (target_height_reg > CFG_W'(h))
            dh = h;
        else
            dh = target_height_reg[POS_W-1:0];
    end

    // Pipeline flow control.
    assign s1_advance = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_advance;
    assign in_accept = s_tvalid && s_tready;

    // Position tracking and pixel selection.
    always_comb
    begin
        // A frame start clears the positions before the pixel is used.
        c_src_col     = s_tuser[0] ? '0 : src_col_reg;
        c_src_row     = s_tuser[0] ? '0 : src_row_reg;
        c_dst_col     = s_tuser[0] ? '0 : dst_col_reg;
        c_dst_row     = s_tuser[0] ? '0 : dst_row_reg;
        c_col_product = s_tuser[0] ? '0 : col_product_reg;
        c_col_base    = s_tuser[0] ? '0 : col_base_reg;
        c_row_product = s_tuser[0] ? '0 : row_product_reg;
        c_row_base    = s_tuser[0] ? '0 : row_base_reg;

        col_sel = (c_dst_col < dw) &&
                  ({1'b0, c_col_product} < ({1'b0, c_col_base} + SUM_W'(dw)));
        row_sel = (c_dst_row < dh) &&
                  ({1'b0, c_row_product} < ({1'b0, c_row_base} + SUM_W'(dh)));
        sel = col_sel && row_sel;
        end_row   = ({1'b0, c_src_col} + (POS_W+1)'(1)) >= {1'b0, w};
        end_frame = ({1'b0, c_src_row} + (POS_W+1)'(1)) >= {1'b0, h};

        src_col_next     = src_col_reg;
        src_row_next     = src_row_reg;
        dst_col_next     = dst_col_reg;
        dst_row_next     = dst_row_reg;
        col_product_next = col_product_reg;
        col_base_next    = col_base_reg;
        row_product_next = row_product_reg;
        row_base_next    = row_base_reg;

        if (in_accept)
        begin
            src_row_next     = c_src_row;
            dst_row_next     = c_dst_row;
            row_product_next = c_row_product;
            row_base_next    = c_row_base;
            if (end_row)
            begin
                src_col_next     = '0;
                dst_col_next     = '0;
                col_product_next = '0;
                col_base_next    = '0;
                if (end_frame)
                begin
                    src_row_next     = '0;
                    dst_row_next     = '0;
                    row_product_next = '0;
                    row_base_next    = '0;
                end
                else
                begin
                    if (row_sel)
                    begin
                        dst_row_next     = c_dst_row + pos_t'(1);
                        row_product_next = c_row_product + PROD_W'(h);
                    end
                    src_row_next  = c_src_row + pos_t'(1);
                    row_base_next = c_row_base + PROD_W'(dh);
                end
            end
            else
            begin
                src_col_next  = c_src_col + pos_t'(1);
                col_base_next = c_col_base + PROD_W'(dw);
                dst_col_next     = sel ? c_dst_col + pos_t'(1) : c_dst_col;
                col_product_next = sel ? c_col_product + PROD_W'(w) : c_col_product;
            end
        end
    end

    always_comb
    begin
        s1_next.red           = s_tdata[7:0];
        s1_next.green         = s_tdata[15:8];
        s1_next.blue          = s_tdata[23:16];
        s1_next.chroma_valid  = !c_dst_row[0] && !c_dst_col[0];
        s1_next.dest_column   = 12'(c_dst_col);
        s1_next.dest_row      = 12'(c_dst_row);
        s1_next.last_of_frame = ({1'b0, c_dst_col} + (POS_W+1)'(1) == {1'b0, dw}) &&
                                ({1'b0, c_dst_row} + (POS_W+1)'(1) == {1'b0, dh});
        if (in_accept)
            s1_valid_next = sel;
        else if (s1_advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg     <= '0;
            src_row_reg     <= '0;
            dst_col_reg     <= '0;
            dst_row_reg     <= '0;
            col_product_reg <= '0;
            col_base_reg    <= '0;
            row_product_reg <= '0;
            row_base_reg    <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            src_col_reg     <= src_col_next;
            src_row_reg     <= src_row_next;
            dst_col_reg     <= dst_col_next;
            dst_row_reg     <= dst_row_next;
            col_product_reg <= col_product_next;
            col_base_reg    <= col_base_next;
            row_product_reg <= row_product_next;
            row_base_reg    <= row_base_next;
            s1_valid_reg    <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_reg <= s1_next;
    end

    // Color conversion. Every chroma difference stays positive thanks to the bias.
    always_comb
    begin
        y_sum  = Y_R * 16'(s1_reg.red) + Y_G * 16'(s1_reg.green) +
                 Y_B * 16'(s1_reg.blue) + ROUND_HALF;
        cb_pos = CB_B * 16'(s1_reg.blue) + CHROMA_BIAS;
        cb_neg = CB_R * 16'(s1_reg.red) + CB_G * 16'(s1_reg.green);
        cr_pos = CR_R * 16'(s1_reg.red) + CHROMA_BIAS;
        cr_neg = CR_G * 16'(s1_reg.green) + CR_B * 16'(s1_reg.blue);
        cb_diff = cb_pos - cb_neg;
        cr_diff = cr_pos - cr_neg;
        luma = y_sum[15:8] + LUMA_OFFSET;
        chroma_blue = s1_reg.chroma_valid ? cb_diff[15:8] : CHROMA_NEUTRAL;
        chroma_red  = s1_reg.chroma_valid ? cr_diff[15:8] : CHROMA_NEUTRAL;
        out_data_next = {s1_reg.dest_row, s1_reg.dest_column, chroma_red, chroma_blue, luma};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
            out_cv_reg   <= s1_reg.chroma_valid;
            out_last_reg <= s1_reg.last_of_frame;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_cv_reg;
    assign m_tlast    = out_last_reg;

    // Chroma is only sampled on even destination rows and columns.
    a_chroma_even: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> !m_tdata[24] && !m_tdata[36])
        else $error("chroma marked valid on an odd row or column");

    a_chroma_neutral: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[15:8] == CHROMA_NEUTRAL &&
                                    m_tdata[23:16] == CHROMA_NEUTRAL)
        else $error("chroma not neutral on a luma-only word");

    a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:0] >= 8'd16 && m_tdata[7:0] <= 8'd235)
        else $error("luma outside studio range");

    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(src_col_reg) && $stable(src_row_reg) &&
                       $stable(dst_col_reg) && $stable(dst_row_reg))
        else $error("positions moved without an accepted pixel");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_reg))
        else $error("pending pixel lost while the output stalled");

endmodule

[test/yuv420_scale_checker.sv]
module yuv420_scale_checker
    import rsyuv_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  dim_t        cfg_data,
    output int          mismatches,
    output int          pending,
    output int          words_checked,
    output int          chroma_words,
    output int          frame_ends
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  luma;
        logic [7:0]  cb;
        logic [7:0]  cr;
        logic        chroma;
        logic [11:0] column;
        logic [11:0] row;
        logic        last;
    } yuv_word_t;

    yuv_word_t expected_words[$];

    dim_t src_width_reg;
    dim_t src_height_reg;
    dim_t dst_width_reg;
    dim_t dst_height_reg;

    int unsigned src_col;
    int unsigned src_row;
    int unsigned dst_col;
    int unsigned dst_row;
    int unsigned col_product;
    int unsigned col_base;
    int unsigned row_product;
    int unsigned row_base;

    function automatic int unsigned limit_size(input int unsigned v, input int unsigned hi);
        if (v < 1)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic void restart_positions();
        src_col = 0;
        src_row = 0;
        dst_col = 0;
        dst_row = 0;
        col_product = 0;
        col_base = 0;
        row_product = 0;
        row_base = 0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Advances the scaler position by one source pixel and queues the word
    // that the pixel produces when it is selected.
    function automatic void predict_pixel(input logic [7:0] red, input logic [7:0] green,
                                          input logic [7:0] blue, input logic frame_start);
        int unsigned w;
        int unsigned h;
        int unsigned dw;
        int unsigned dh;
        int r;
        int g;
        int b;
        bit row_hit;
        bit col_hit;
        yuv_word_t word;

        w = limit_size(src_width_reg, MAX_DIMENSION);
        h = limit_size(src_height_reg, MAX_DIMENSION);
        dw = limit_size(dst_width_reg, w);
        dh = limit_size(dst_height_reg, h);
        r = red;
        g = green;
        b = blue;

        if (frame_start)
        begin
            restart_positions();
        end

        row_hit = dst_row < dh && row_product < row_base + dh;
        col_hit = dst_col < dw && col_product < col_base + dw;

        if (row_hit && col_hit)
        begin
            word.luma = 8'(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
            word.chroma = !dst_row[0] && !dst_col[0];
            word.cb = 8'd128;
            word.cr = 8'd128;
            if (word.chroma)
            begin
                // The chroma offset sits above the shift, so the sum never goes negative.
                word.cb = 8'((-38 * r - 74 * g + 112 * b + 32896) >>> 8);
                word.cr = 8'((112 * r - 94 * g - 18 * b + 32896) >>> 8);
            end
            word.column = dst_col[11:0];
            word.row = dst_row[11:0];
            word.last = (dst_col + 1 == dw) && (dst_row + 1 == dh);
            expected_words.push_back(word);
            dst_col++;
            col_product += w;
        end

        if (src_col + 1 >= w)
        begin
            src_col = 0;
            dst_col = 0;
            col_product = 0;
            col_base = 0;
            if (src_row + 1 >= h)
            begin
                restart_positions();
            end
            else
            begin
                if (row_hit)
                begin
                    dst_row++;
                    row_product += h;
                end
                src_row++;
                row_base += dh;
            end
        end
        else
        begin
            src_col++;
            col_base += dw;
        end
    endfunction

    task automatic check_word(input logic [47:0] data, input logic chroma, input logic last);
        yuv_word_t got;
        yuv_word_t want;

        got.luma = data[7:0];
        got.cb = data[15:8];
        got.cr = data[23:16];
        got.column = data[35:24];
        got.row = data[47:36];
        got.chroma = chroma;
        got.last = last;

        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf("output word with none expected: col %0d row %0d luma %0d",
                                      got.column, got.row, got.luma));
            return;
        end
        want = expected_words.pop_front();
        if (got.luma !== want.luma)
        begin
            report_mismatch($sformatf("luma got %0d expected %0d", got.luma, want.luma));
        end
        if (got.cb !== want.cb)
        begin
            report_mismatch($sformatf("Cb got %0d expected %0d", got.cb, want.cb));
        end
        if (got.cr !== want.cr)
        begin
            report_mismatch($sformatf("Cr got %0d expected %0d", got.cr, want.cr));
        end
        if (got.chroma !== want.chroma)
        begin
            report_mismatch($sformatf("chroma flag got %0b expected %0b", got.chroma, want.chroma));
        end
        if (got.column !== want.column)
        begin
            report_mismatch($sformatf("column got %0d expected %0d", got.column, want.column));
        end
        if (got.row !== want.row)
        begin
            report_mismatch($sformatf("row got %0d expected %0d", got.row, want.row));
        end
        if (got.last !== want.last)
        begin
            report_mismatch($sformatf("frame end flag got %0b expected %0b", got.last, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg = RESET_SOURCE_WIDTH;
            src_height_reg = RESET_SOURCE_HEIGHT;
            dst_width_reg = RESET_TARGET_WIDTH;
            dst_height_reg = RESET_TARGET_HEIGHT;
            restart_positions();
            expected_words.delete();
            pending <= 0;
        end
        else
        begin
            // Outputs are compared before this edge's input is predicted, so a
            // word can never match an expectation queued at the same edge.
            if (m_tvalid && m_tready)
            begin
                check_word(m_tdata, m_tuser[0], m_tlast);
                words_checked++;
                if (m_tuser[0] === 1'b1)
                begin
                    chroma_words++;
                end
                if (m_tlast === 1'b1)
                begin
                    frame_ends++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SOURCE_WIDTH:  src_width_reg = cfg_data;
                    REG_SOURCE_HEIGHT: src_height_reg = cfg_data;
                    REG_TARGET_WIDTH:  dst_width_reg = cfg_data;
                    REG_TARGET_HEIGHT: dst_height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                predict_pixel(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tuser[0]);
            end
            pending <= expected_words.size();
        end
    end

endmodule

[test/tb_top.sv]
module tb_top;
    import rsyuv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM = 4096;
    localparam int RANDOM_PIXELS = 950;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [11:0][23:0] EXTREME_COLORS = {
        24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h00FFFF,
        24'hFFFF00, 24'hFF00FF, 24'h808080, 24'h040201, 24'hAA55AA, 24'h55AA55
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    dim_t        cfg_data;

    int mismatches;
    int pending;
    int words_checked;
    int chroma_words;
    int frame_ends;

    int cycle_count = 0;
    int pixels_sent = 0;
    int size_settings = 0;
    int sender_idle_pct = 0;
    int stall_pct = 0;
    bit hold_request = 1'b0;

    rgb_scale_to_yuv420 #(.MAX_DIMENSION(MAX_DIM)) dut (.*);

    yuv420_scale_checker #(.MAX_DIMENSION(MAX_DIM)) yuv_check (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("Timeout after %0d cycles with %0d words outstanding", cycle_count, pending);
        $display("Some tests failed");
        $finish;
    end

    // Output side: random stalls, and on request one long hold-off so the
    // pipeline fills up and pushes back on the input.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [7:0] pick_channel();
        if ($urandom_range(9) == 0)
        begin
            return $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [23:0] pick_color();
        return {pick_channel(), pick_channel(), pick_channel()};
    endfunction

    task automatic send_pixel(input logic [23:0] color, input logic frame_start);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= color;
        s_tuser <= frame_start;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        pixels_sent++;
    endtask

    task automatic write_register(input cfg_index_t index, input dim_t value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_sizes(input dim_t src_w, input dim_t src_h,
                               input dim_t dst_w, input dim_t dst_h);
        write_register(REG_SOURCE_WIDTH, src_w);
        write_register(REG_SOURCE_HEIGHT, src_h);
        write_register(REG_TARGET_WIDTH, dst_w);
        write_register(REG_TARGET_HEIGHT, dst_h);
        cfg_valid <= 1'b0;
        size_settings++;
    endtask

    // Stops offering pixels and waits until every expected word has left,
    // plus the pipeline depth for pixels that produce nothing.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic send_run(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_pixel(pick_color(), i == 0);
        end
    endtask

    // Mostly complete frames; the rest are cut short, lack a frame start, or
    // carry frame starts at random places.
    task automatic send_frame(input int unsigned w, input int unsigned h);
        int unsigned total;
        int unsigned count;
        int kind;

        total = w * h;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            send_run(total);
        end
        else if (kind < 80)
        begin
            send_run($urandom_range(1, total));
        end
        else if (kind < 90)
        begin
            for (int i = 0; i < total; i++)
            begin
                send_pixel(pick_color(), 1'b0);
            end
        end
        else
        begin
            count = $urandom_range(1, total);
            for (int i = 0; i < count; i++)
            begin
                send_pixel(pick_color(), $urandom_range(5) == 0);
            end
        end
    endtask

    initial
    begin
        int phase;
        int target_count;
        int unsigned w;
        int unsigned h;
        int unsigned dw;
        int unsigned dh;
        int frames;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_SOURCE_WIDTH;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sizes left at their reset values.
        for (int i = 0; i < 6; i++)
        begin
            send_pixel(EXTREME_COLORS[i], i == 0);
        end
        wait_drained();

        // Odd target width, a frame that ends, then a restart in mid-frame.
        write_sizes(13'd4, 13'd3, 13'd3, 13'd2);
        for (int i = 0; i < 12; i++)
        begin
            send_pixel(EXTREME_COLORS[i], i == 0);
        end
        for (int i = 0; i < 4; i++)
        begin
            send_pixel(EXTREME_COLORS[11 - i], i == 2);
        end
        wait_drained();

        phase = 0;
        target_count = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < target_count)
        begin
            case (phase % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 57;
                    stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct = 57;
                end
                default:
                begin
                    sender_idle_pct = 33;
                    stall_pct = 33;
                end
            endcase
            if (phase % 8 == 2)
            begin
                hold_request = 1'b1;
            end

            case (phase)
                1:
                begin
                    write_sizes(13'd4096, 13'd2, 13'd4096, 13'd2);
                    send_run(40);
                end
                3:
                begin
                    write_sizes(13'd8191, 13'd8191, 13'd8191, 13'd8191);
                    send_run(40);
                end
                5:
                begin
                    // Every size clamps to one: each pixel is a whole frame.
                    write_sizes(13'd0, 13'd0, 13'd0, 13'd0);
                    send_run(30);
                end
                7:
                begin
                    write_sizes(13'd2, 13'd4096, 13'd8191, 13'd0);
                    send_run(40);
                end
                9:
                begin
                    write_sizes(13'd4096, 13'd4096, 13'd1, 13'd4096);
                    send_run(40);
                end
                default:
                begin
                    w = $urandom_range(1, 16);
                    h = $urandom_range(1, 10);
                    dw = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, w + 3);
                    dh = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, h + 3);
                    write_sizes(13'(w), 13'(h), 13'(dw), 13'(dh));
                    frames = $urandom_range(1, 3);
                    for (int f = 0; f < frames; f++)
                    begin
                        send_frame(w, h);
                    end
                end
            endcase
            wait_drained();
            phase++;
        end

        repeat (10) @(posedge clk);
        $display("Sent %0d source pixels over %0d size settings, with sender gaps,", pixels_sent,
                 size_settings);
        $display("receiver stalls and a long hold-off; checked %0d words (%0d with chroma, %0d frame ends).",
                 words_checked, chroma_words, frame_ends);
        if (mismatches == 0 && pending == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/rsyuv_pkg.sv
rtl/core/rgb_scale_to_yuv420.sv
test/yuv420_scale_checker.sv
test/tb_top.sv
